[sv/phfm_pkg.sv]
// Shared constants and types for the peer heartbeat failover monitor.
// Field widths, command codes, role and peer health codes, register indexes.
// No dependencies.
package phfm_pkg;

  // Field widths
  localparam int TIME_W   = 64;
  localparam int IVL_W    = 40;
  localparam int THR_W    = 16;
  localparam int GEN_W    = 64;
  localparam int MODE_W   = 3;
  localparam int ROLE_W   = 2;
  localparam int HEALTH_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 40;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_HEARTBEAT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CHECK     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PROMOTE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEMOTE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_START     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_STOP      = 3'd5;

  // Roles
  localparam logic [ROLE_W-1:0] ROLE_SOLO    = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_PRIMARY = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_STANDBY = 2'd2;
  localparam logic [ROLE_W-1:0] ROLE_RSVD    = 2'd3;

  // Peer health
  localparam logic [HEALTH_W-1:0] PEER_UNKNOWN = 2'd0;
  localparam logic [HEALTH_W-1:0] PEER_ALIVE   = 2'd1;
  localparam logic [HEALTH_W-1:0] PEER_SUSPECT = 2'd2;
  localparam logic [HEALTH_W-1:0] PEER_DEAD    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSPECT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_FO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_ROLE = 3'd4;

  // Register reset values
  localparam logic [IVL_W-1:0] INTERVAL_RST = 40'd1000000000;
  localparam logic [THR_W-1:0] SUSPECT_RST  = 16'd3;
  localparam logic [THR_W-1:0] DEAD_RST     = 16'd5;

  // Result of one transfer on the output side
  typedef struct packed {
    logic                status;
    logic                role_changed;
    logic [ROLE_W-1:0]   old_role;
    logic [ROLE_W-1:0]   current_role;
    logic [HEALTH_W-1:0] peer_health;
    logic [GEN_W-1:0]    generation_count;
    logic                is_running;
  } result_t;

  // Handshake status of the divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/phfm_div.sv]
// Radix-2 restoring divider: one quotient bit per cycle, MSB first.
// Dividend and quotient share one shift register. Uses phfm_pkg for div_stat_t.
module phfm_div
  import phfm_pkg::*;
#(
  parameter int DW = 64,
  parameter int VW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output div_stat_t     stat,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW);

  logic [DW-1:0] dq_r, dq_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dv_r, dv_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          q_bit;

  // One shift-and-subtract step
  assign rem_sh  = {rem_r, dq_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dv_r};
  assign q_bit   = (rem_sh >= {1'b0, dv_r});

  always_comb begin
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dv_nxt   = divisor;
      cnt_nxt  = CW'(DW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DW-2:0], q_bit};
      rem_nxt = q_bit ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    cnt_r <= cnt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");
  a_last_step_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == '0 && !start) |=> done_r) else $error("divider missed done");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held longer than one cycle");
`endif

endmodule

[sv/peer_heartbeat_failover_monitor_top.sv]
// Peer heartbeat failure detector with failover: command decode, role and peer state,
// output register. Uses phfm_pkg and the bit-serial divider phfm_div.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_ready    | in_mode, in_time_ns
//   out_    | output    | out_valid / out_ready  | status, roles, health, generation, run
//   cfg_    | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// Most commands are registered at the accept edge. A health check that needs the
// missed-interval count goes through the divider (start, 64 quotient bits, finish)
// and is registered once the divider is done; in_ready stays low in the meantime.
// Reset is synchronous, active low. in_ready is high when no check is in the
// divider and the output register is empty or being drained this cycle.
module peer_heartbeat_failover_monitor_top
  import phfm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [TIME_W-1:0]    in_time_ns,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_status,
  output logic                 out_role_changed,
  output logic [ROLE_W-1:0]    out_old_role,
  output logic [ROLE_W-1:0]    out_current_role,
  output logic [HEALTH_W-1:0]  out_peer_health,
  output logic [GEN_W-1:0]     out_generation_count,
  output logic                 out_is_running
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  // Configuration
  logic [IVL_W-1:0] interval_r, interval_nxt;
  logic [THR_W-1:0] suspect_r, suspect_nxt;
  logic [THR_W-1:0] dead_r, dead_nxt;
  logic             auto_fo_r, auto_fo_nxt;

  // Monitor state
  logic [ROLE_W-1:0]   role_r, role_nxt;
  logic [HEALTH_W-1:0] peer_r, peer_nxt;
  logic [GEN_W-1:0]    gen_r, gen_nxt;
  logic [TIME_W-1:0]   last_hb_r, last_hb_nxt;
  logic                run_r, run_nxt;
  logic                state_r, state_nxt;

  // Output register
  logic    out_valid_r, out_valid_nxt;
  result_t res_r, res_nxt;
  logic    out_load;

  // Datapath helpers
  logic              accept;
  logic [TIME_W:0]   diff_ext;
  logic              not_past;
  logic              div_start;
  div_stat_t         div_stat;
  logic [TIME_W-1:0] quotient;
  logic              dead_hit;
  logic              suspect_hit;
  logic [ROLE_W-1:0] cfg_role;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // Elapsed time and "not past the heartbeat" from one subtractor
  assign diff_ext = {1'b0, in_time_ns} - {1'b0, last_hb_r};
  assign not_past = diff_ext[TIME_W] || (diff_ext[TIME_W-1:0] == '0);

  // Grade the quotient against the thresholds
  assign dead_hit    = (quotient[TIME_W-1:THR_W] != '0) || (quotient[THR_W-1:0] >= dead_r);
  assign suspect_hit = (quotient[TIME_W-1:THR_W] != '0) ||
                       (quotient[THR_W-1:0] >= suspect_r);

  assign cfg_role = (cfg_wdata[ROLE_W-1:0] == ROLE_RSVD) ? ROLE_SOLO : cfg_wdata[ROLE_W-1:0];

  phfm_div #(
    .DW(TIME_W),
    .VW(IVL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_ext[TIME_W-1:0]),
    .divisor  (interval_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Command decode, divider completion and configuration writes
  always_comb begin
    interval_nxt = interval_r;
    suspect_nxt  = suspect_r;
    dead_nxt     = dead_r;
    auto_fo_nxt  = auto_fo_r;
    role_nxt     = role_r;
    peer_nxt     = peer_r;
    gen_nxt      = gen_r;
    last_hb_nxt  = last_hb_r;
    run_nxt      = run_r;
    state_nxt    = state_r;
    div_start    = 1'b0;
    out_load     = 1'b0;
    res_nxt              = res_r;
    res_nxt.status       = 1'b0;
    res_nxt.role_changed = 1'b0;
    res_nxt.old_role     = role_r;

    if (accept) begin
      out_load = 1'b1;
      unique case (in_mode)
        MODE_HEARTBEAT: begin
          last_hb_nxt = in_time_ns;
          peer_nxt    = PEER_ALIVE;
        end
        MODE_CHECK: begin
          if (run_r && (last_hb_r != '0)) begin
            if (not_past) begin
              peer_nxt = PEER_ALIVE;
            end else if (interval_r != '0) begin
              // Missed-interval count goes through the divider
              div_start = 1'b1;
              out_load  = 1'b0;
              state_nxt = ST_DIV;
            end
          end
        end
        MODE_PROMOTE: begin
          if (role_r == ROLE_STANDBY) begin
            role_nxt             = ROLE_PRIMARY;
            gen_nxt              = gen_r + 1'b1;
            res_nxt.role_changed = 1'b1;
          end else begin
            res_nxt.status = 1'b1;
          end
        end
        MODE_DEMOTE: begin
          if (role_r == ROLE_PRIMARY) begin
            role_nxt             = ROLE_STANDBY;
            gen_nxt              = gen_r + 1'b1;
            res_nxt.role_changed = 1'b1;
          end else begin
            res_nxt.status = 1'b1;
          end
        end
        MODE_START: run_nxt = 1'b1;
        MODE_STOP:  run_nxt = 1'b0;
        default: ;
      endcase
    end else if (div_stat.done) begin
      // Finish a health check
      out_load  = 1'b1;
      state_nxt = ST_IDLE;
      if (dead_hit) begin
        peer_nxt = PEER_DEAD;
        if (auto_fo_r && role_r == ROLE_STANDBY) begin
          role_nxt             = ROLE_PRIMARY;
          gen_nxt              = gen_r + 1'b1;
          res_nxt.role_changed = 1'b1;
        end
      end else if (suspect_hit) begin
        peer_nxt = PEER_SUSPECT;
      end else begin
        peer_nxt = PEER_ALIVE;
      end
    end

    // Register writes arrive only while idle: the user must keep to this; the block does not enforce it
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERVAL:  interval_nxt = cfg_wdata[IVL_W-1:0];
        CFG_SUSPECT:   suspect_nxt  = cfg_wdata[THR_W-1:0];
        CFG_DEAD:      dead_nxt     = cfg_wdata[THR_W-1:0];
        CFG_AUTO_FO:   auto_fo_nxt  = cfg_wdata[0];
        CFG_INIT_ROLE: role_nxt     = cfg_role;
        default: ;
      endcase
    end

    res_nxt.current_role     = role_nxt;
    res_nxt.peer_health      = peer_nxt;
    res_nxt.generation_count = gen_nxt;
    res_nxt.is_running       = run_nxt;

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= INTERVAL_RST;
      suspect_r   <= SUSPECT_RST;
      dead_r      <= DEAD_RST;
      auto_fo_r   <= 1'b0;
      role_r      <= ROLE_SOLO;
      peer_r      <= PEER_UNKNOWN;
      gen_r       <= '0;
      last_hb_r   <= '0;
      run_r       <= 1'b0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      interval_r  <= interval_nxt;
      suspect_r   <= suspect_nxt;
      dead_r      <= dead_nxt;
      auto_fo_r   <= auto_fo_nxt;
      role_r      <= role_nxt;
      peer_r      <= peer_nxt;
      gen_r       <= gen_nxt;
      last_hb_r   <= last_hb_nxt;
      run_r       <= run_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = res_r.status;
  assign out_role_changed     = res_r.role_changed;
  assign out_old_role         = res_r.old_role;
  assign out_current_role     = res_r.current_role;
  assign out_peer_health      = res_r.peer_health;
  assign out_generation_count = res_r.generation_count;
  assign out_is_running       = res_r.is_running;

`ifndef SYNTH
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV)) else $error("divider done outside a check");
  a_out_empty_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !out_valid_r) else $error("result pending during divide");
  a_role_legal: assert property (@(posedge clk) disable iff (!rst_n)
    role_r != ROLE_RSVD) else $error("reserved role code held");
  a_gen_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && gen_r != $past(gen_r)) |-> (out_valid_r && res_r.role_changed))
    else $error("generation moved without a flagged role change");
`endif

endmodule
